// ===== hdl/ldith_pkg.sv =====
// Package for the luma Floyd-Steinberg ditherer.
// Holds shared constants, types and the saturation helper.
// No dependencies; compiled before every other file of the block.
package ldith_pkg;

   localparam int DEFAULT_MAX_WIDTH = 128;
   localparam int QUEUE_DEPTH       = 2;

   localparam int COLOR_W  = 8;
   localparam int COLUMN_W = 7;
   localparam int ROW_W    = 8;
   localparam int LUMA_W   = 16;
   localparam int ERR_W    = 21;
   localparam int CFG_W    = 8;
   localparam int CSR_IDX_W = 2;

   // Luma weights 0.299, 0.587, 0.114 in Q0.16 and the rounding term.
   localparam logic [24:0] LUMA_R_WEIGHT = 25'd19595;
   localparam logic [24:0] LUMA_G_WEIGHT = 25'd38470;
   localparam logic [24:0] LUMA_B_WEIGHT = 25'd7471;
   localparam logic [24:0] LUMA_ROUND    = 25'd128;

   // Value of a light pixel, 255.0 in Q12.8.
   localparam logic signed [ERR_W-1:0] LIGHT_LEVEL = 21'sd65280;
   localparam logic signed [22:0] Q_MAX = 23'sd1048575;
   localparam logic signed [22:0] Q_MIN = -23'sd1048576;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 2'd2;

   localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 8'd84;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 8'd48;
   localparam logic [CFG_W-1:0] THRESHOLD_RESET    = 8'd128;

   typedef struct packed {
      logic [CFG_W-1:0] line_width;
      logic [CFG_W-1:0] frame_height;
      logic [CFG_W-1:0] threshold;
   } cfg_type;

   // One classified pixel on its way from the front to the back.
   typedef struct packed {
      logic [LUMA_W-1:0]   luma;
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      logic                last_col;
      logic                last_row;
   } item_type;

   function automatic logic signed [ERR_W-1:0] sat21(input logic signed [22:0] v);
      logic signed [ERR_W-1:0] r;
      if (v > Q_MAX) begin
         r = Q_MAX[ERR_W-1:0];
      end else if (v < Q_MIN) begin
         r = Q_MIN[ERR_W-1:0];
      end else begin
         r = v[ERR_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/ldith_req_if.sv =====
// Pixel request channel: valid/ready handshake with an RGB888 payload.
// Depends on ldith_pkg for field widths.
interface ldith_req_if;
   logic                           valid;
   logic                           ready;
   logic [ldith_pkg::COLOR_W-1:0]  red;
   logic [ldith_pkg::COLOR_W-1:0]  green;
   logic [ldith_pkg::COLOR_W-1:0]  blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== hdl/ldith_rsp_if.sv =====
// Dithered pixel response channel: valid/ready handshake with position fields.
// Depends on ldith_pkg for field widths.
interface ldith_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            pixel_dark;
   logic [ldith_pkg::COLUMN_W-1:0]  column;
   logic [ldith_pkg::ROW_W-1:0]     row;
   logic                            frame_last;

   modport source (output valid, pixel_dark, column, row, frame_last, input ready);
   modport sink   (input valid, pixel_dark, column, row, frame_last, output ready);
endinterface

// ===== hdl/ldith_front.sv =====
// Front end: accepts request beats, tracks column and row, computes luma.
// Depends on ldith_pkg and ldith_req_if; feeds ldith_queue.
module ldith_front #(
   parameter int MAX_WIDTH = ldith_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   ldith_req_if.sink            req_chan,
   input  ldith_pkg::cfg_type   cfg,
   output logic                 push_valid,
   input  logic                 push_ready,
   output ldith_pkg::item_type  push_item
);

   localparam int WidthCap = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
   localparam logic [ldith_pkg::CFG_W-1:0] WIDTH_CAP = ldith_pkg::CFG_W'(WidthCap);

   logic [ldith_pkg::COLUMN_W-1:0] col_ff, col_in;
   logic [ldith_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [ldith_pkg::CFG_W-1:0]    width_eff, height_eff;
   logic                           last_col, last_row, accept;
   logic [24:0]                    red_w, green_w, blue_w, luma_acc;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign accept         = req_chan.valid && push_ready;

   always_comb begin
      priority if (cfg.line_width < 8'd2) begin
         width_eff = 8'd2;
      end else if (cfg.line_width > WIDTH_CAP) begin
         width_eff = WIDTH_CAP;
      end else begin
         width_eff = cfg.line_width;
      end
      height_eff = (cfg.frame_height == 8'd0) ? 8'd1 : cfg.frame_height;
   end

   // A counter at or beyond the last position ends the row or frame.
   assign last_col = {1'b0, col_ff} >= (width_eff - 8'd1);
   assign last_row = row_ff >= (height_eff - 8'd1);

   assign red_w    = 25'(req_chan.red);
   assign green_w  = 25'(req_chan.green);
   assign blue_w   = 25'(req_chan.blue);
   assign luma_acc = ldith_pkg::LUMA_R_WEIGHT * red_w + ldith_pkg::LUMA_G_WEIGHT * green_w
                   + ldith_pkg::LUMA_B_WEIGHT * blue_w + ldith_pkg::LUMA_ROUND;

   always_comb begin
      push_item.luma     = luma_acc[8 +: ldith_pkg::LUMA_W];
      push_item.column   = col_ff;
      push_item.row      = row_ff;
      push_item.last_col = last_col;
      push_item.last_row = last_row;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 8'd1;
         end else begin
            col_in = col_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== hdl/ldith_queue.sv =====
// Short queue that decouples the front end from the dithering back end.
// Depends on ldith_pkg for the item type and depth.
module ldith_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  ldith_pkg::item_type  push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output ldith_pkg::item_type  pop_item
);

   localparam int Depth  = ldith_pkg::QUEUE_DEPTH;
   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   ldith_pkg::item_type entries_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != CountW'(Depth);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/ldith_back.sv =====
// Back end: line buffer read, error diffusion, threshold and response register.
// Depends on ldith_pkg and ldith_rsp_if; fed by ldith_queue.
module ldith_back #(
   parameter int MAX_WIDTH = ldith_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ldith_pkg::cfg_type   cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  ldith_pkg::item_type  pop_item,
   ldith_rsp_if.source          rsp_chan
);

   localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW    = ldith_pkg::ERR_W;

   logic signed [EW-1:0] lbuf_mem [MAX_WIDTH];

   ldith_pkg::item_type  stage_item_ff;
   logic                 stage_valid_ff;
   logic signed [EW-1:0] stage_err_ff;

   logic                                out_valid_ff, out_dark_ff, out_last_ff;
   logic [ldith_pkg::COLUMN_W-1:0]      out_col_ff;
   logic [ldith_pkg::ROW_W-1:0]         out_row_ff;

   logic signed [EW-1:0] right_carry_ff, right_carry_in;
   logic signed [EW-1:0] diag_ff, diag_in, below_ff, below_in;

   logic                 park_valid_ff, park_valid_in;
   logic [AddrW-1:0]     park_addr_ff;
   logic signed [EW-1:0] park_data_ff;

   logic                 out_load, stage_load;
   logic [AddrW-1:0]     rd_addr, mem_waddr, comp_waddr;
   logic                 mem_we, comp_we;
   logic signed [EW-1:0] mem_wdata, comp_wdata;

   logic signed [EW-1:0] val_part, val, err, above_err;
   logic signed [EW-1:0] s7, s3, s5, s1, below_next;
   logic signed [24:0]   err_x;
   logic                 dark;
   logic signed [EW-1:0] thresh_q;

   assign out_load   = stage_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign pop_ready  = !stage_valid_ff || out_load;
   assign stage_load = pop_valid && pop_ready;
   assign rd_addr    = AddrW'(pop_item.column);

   // Pixel math on the item in the read stage.
   always_comb begin
      thresh_q  = $signed({5'b0, cfg.threshold, 8'b0});
      above_err = (stage_item_ff.row != '0) ? stage_err_ff : '0;
      val_part  = ldith_pkg::sat21($signed({7'b0, stage_item_ff.luma})
                                   + 23'(right_carry_ff));
      val       = ldith_pkg::sat21(23'(val_part) + 23'(above_err));
      dark      = val < thresh_q;
      err       = ldith_pkg::sat21(23'(val) - (dark ? 23'sd0 : 23'(ldith_pkg::LIGHT_LEVEL)));
      err_x     = 25'(err);
      s7        = EW'(((err_x <<< 3) - err_x) >>> 4);
      s3        = EW'(((err_x <<< 1) + err_x) >>> 4);
      s5        = EW'(((err_x <<< 2) + err_x) >>> 4);
      s1        = EW'(err_x >>> 4);
      below_next = ldith_pkg::sat21(23'(diag_ff) + 23'(s5));
   end

   // The lower-left share goes to the line buffer now; at the end of a row the
   // share below the last column is parked and written in the following cycle.
   always_comb begin
      comp_we    = out_load && !stage_item_ff.last_row && (stage_item_ff.column != '0);
      comp_waddr = AddrW'(stage_item_ff.column - 7'd1);
      comp_wdata = ldith_pkg::sat21(23'(below_ff) + 23'(s3));
      park_valid_in = out_load && !stage_item_ff.last_row && stage_item_ff.last_col;

      mem_we    = park_valid_ff || comp_we;
      mem_waddr = park_valid_ff ? park_addr_ff : comp_waddr;
      mem_wdata = park_valid_ff ? park_data_ff : comp_wdata;
   end

   always_comb begin
      right_carry_in = right_carry_ff;
      diag_in        = diag_ff;
      below_in       = below_ff;
      if (out_load) begin
         if (!stage_item_ff.last_row) begin
            below_in = below_next;
            diag_in  = s1;
         end
         if (stage_item_ff.last_col) begin
            right_carry_in = '0;
            diag_in        = '0;
            below_in       = '0;
         end else begin
            right_carry_in = s7;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         park_valid_ff  <= 1'b0;
         right_carry_ff <= '0;
         diag_ff        <= '0;
         below_ff       <= '0;
      end else begin
         if (stage_load) begin
            stage_valid_ff <= 1'b1;
         end else if (out_load) begin
            stage_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         park_valid_ff  <= park_valid_in;
         right_carry_ff <= right_carry_in;
         diag_ff        <= diag_in;
         below_ff       <= below_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load) begin
         stage_item_ff <= pop_item;
      end
      if (out_load) begin
         out_dark_ff <= dark;
         out_col_ff  <= stage_item_ff.column;
         out_row_ff  <= stage_item_ff.row;
         out_last_ff <= stage_item_ff.last_col && stage_item_ff.last_row;
      end
      if (park_valid_in) begin
         park_addr_ff <= AddrW'(stage_item_ff.column);
         park_data_ff <= below_next;
      end
   end

   // Line buffer: one write and one registered read per cycle, with the
   // write of the same cycle forwarded to the read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lbuf_mem[mem_waddr] <= mem_wdata;
      end
      if (stage_load) begin
         stage_err_ff <= (mem_we && mem_waddr == rd_addr) ? mem_wdata : lbuf_mem[rd_addr];
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pixel_dark = out_dark_ff;
   assign rsp_chan.column     = out_col_ff;
   assign rsp_chan.row        = out_row_ff;
   assign rsp_chan.frame_last = out_last_ff;

endmodule

// ===== hdl/luma_floyd_steinberg_dither.sv =====
// Top level of the luma Floyd-Steinberg ditherer: configuration registers,
// front end, decoupling queue and back end. Depends on ldith_pkg, the channel
// interfaces, ldith_front, ldith_queue and ldith_back.
//
// Usage: RGB888 pixels arrive in raster order on req_chan, one per beat. Each
// beat yields exactly one beat on rsp_chan carrying the one-bit dithered value,
// its column and row, and a flag on the last pixel of the frame.
// Throughput is one pixel per clock cycle while rsp_chan.ready is high; it is
// set by the error carry to the right neighbor, held in a back end register.
// An accepted request beat enters the queue at the accepting edge, then moves
// into the line buffer read stage and from there into the response register,
// which drives its response beat on rsp_chan.
// The line buffer has one write and one read port; the second write at the
// end of each row but the last is registered and written in the next cycle.
// Reset restores line_width 84, frame_height 48 and threshold 128, clears
// the position counters and the diffused error, and empties the pipeline. The
// line buffer is not cleared; row 0 ignores what it reads from it.
// When the receiver holds off rsp_chan.ready, the response register holds its
// beat, the back end stops, the queue fills and then req_chan.ready falls.
// The user writes the csr port only while the block is idle; it is unenforced.
module luma_floyd_steinberg_dither #(
   parameter int MAX_WIDTH = ldith_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   ldith_req_if.sink                           req_chan,
   ldith_rsp_if.source                         rsp_chan,
   input  logic                                csr_we,
   input  logic [ldith_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ldith_pkg::CFG_W-1:0]         csr_data
);

   logic [ldith_pkg::CFG_W-1:0] line_width_ff, frame_height_ff, threshold_ff;
   ldith_pkg::cfg_type          cfg;
   logic                        push_valid, push_ready, pop_valid, pop_ready;
   ldith_pkg::item_type         push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= ldith_pkg::LINE_WIDTH_RESET;
         frame_height_ff <= ldith_pkg::FRAME_HEIGHT_RESET;
         threshold_ff    <= ldith_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ldith_pkg::CSR_LINE_WIDTH: begin
               line_width_ff <= csr_data;
            end
            ldith_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data;
            end
            ldith_pkg::CSR_THRESHOLD: begin
               threshold_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.line_width   = line_width_ff;
      cfg.frame_height = frame_height_ff;
      cfg.threshold    = threshold_ff;
   end

   ldith_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   ldith_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   ldith_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan)
   );

endmodule
